[src/array_list_table_engine_macros.svh]
// Assertion macros shared by the ordered list engine RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef ARRAY_LIST_TABLE_ENGINE_MACROS_SVH
`define ARRAY_LIST_TABLE_ENGINE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ALTE_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication.
`define ALTE_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ALTE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[src/alte_pkg.sv]
// Package of the ordered list engine: sizes, codes, item types and helpers.
// Used by alte_front, alte_back and array_list_table_engine.
`default_nettype none

package alte_pkg;

   localparam int unsigned DEPTH       = 64;
   localparam int unsigned IDX_W       = $clog2(DEPTH);
   localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
   localparam int unsigned OUT_LIMIT   = 64;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CMD_W  = 3;
   localparam int unsigned VAL_W  = 16;
   localparam int unsigned POS_W  = 6;
   localparam int unsigned STAT_W = 3;
   localparam int unsigned RCNT_W = 7;
   localparam int unsigned CMP_W  = CNT_W + POS_W;

   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(OUT_LIMIT);

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_SEARCH = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_SORT   = 3'd4,
      CMD_DUMP   = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      OP_APPEND,
      OP_SEARCH,
      OP_DELETE,
      OP_INSERT,
      OP_SORT,
      OP_DUMP,
      OP_NOP
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE      = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_EMPTY     = 3'd3,
      STAT_BAD_POS   = 3'd4,
      STAT_ENTRY     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH,
      S_SHIFT,
      S_SORT
   } state_type;

   typedef struct packed {
      op_type            op;
      logic [VAL_W-1:0]  value;
      logic [POS_W-1:0]  position;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   // Reported positions keep their low six bits.
   function automatic logic [POS_W-1:0] rpt_pos(input logic [CNT_W-1:0] p);
      logic [CNT_W+POS_W-1:0] w;
      w = {{POS_W{1'b0}}, p};
      return w[POS_W-1:0];
   endfunction

   // Reported counts keep their low seven bits.
   function automatic logic [RCNT_W-1:0] rpt_count(input logic [CNT_W-1:0] c);
      logic [CNT_W+RCNT_W-1:0] w;
      w = {{RCNT_W{1'b0}}, c};
      return w[RCNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

[src/array_list_table_engine.sv]
// Ordered list engine: a two-item command queue feeds one sequencer that owns the list memory.
// One item runs in the sequencer at a time.
// Reset clears the count, the queue and the sequencer; list entries hold until written.
// Results cannot be stalled: each one shows for a single cycle with rsp_valid high.
`default_nettype none

module array_list_table_engine import alte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [VAL_W-1:0]     req_value,
   input  logic [POS_W-1:0]     req_position,
   output logic                 rsp_valid,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [POS_W-1:0]     rsp_entry_position,
   output logic [VAL_W-1:0]     rsp_entry_value,
   output logic [RCNT_W-1:0]    rsp_list_count,
   output logic                 rsp_last
);

   // The head of the queue as seen by the sequencer, and its pop request.
   queue_head_type head;
   logic           pop;

   // The front end takes an item whenever its queue has room, so a new item
   // can wait while the sequencer is still walking the list for the previous one.
   // busy rises only when both queue slots are occupied.
   alte_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_command  (req_command),
      .req_value    (req_value),
      .req_position (req_position),
      .pop          (pop),
      .busy         (busy),
      .head         (head)
   );

   // The back end pops one item when it is idle and runs it to completion.
   // Every memory walk reads one entry per cycle; shifts write the entry read
   // on the previous cycle, and sort keeps the running minimum in a register.
   // All results leave through a registered output stage.
   alte_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_entry_position (rsp_entry_position),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_list_count     (rsp_list_count),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

[src/alte_front.sv]
// Front end of the ordered list engine: decodes commands and queues items.
// Depends on alte_pkg and array_list_table_engine_macros.svh.
`default_nettype none
`include "array_list_table_engine_macros.svh"

module alte_front import alte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [VAL_W-1:0]     req_value,
   input  logic [POS_W-1:0]     req_position,
   input  logic                 pop,
   output logic                 busy,
   output queue_head_type       head
);

   item_type             slot_ff [QUEUE_DEPTH];
   item_type             item_in;
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                 push;

   // Classify the command; codes without a meaning become a no-op.
   always_comb begin
      item_in.value    = req_value;
      item_in.position = req_position;
      case (cmd_type'(req_command))
         CMD_APPEND: item_in.op = OP_APPEND;
         CMD_SEARCH: item_in.op = OP_SEARCH;
         CMD_DELETE: item_in.op = OP_DELETE;
         CMD_INSERT: item_in.op = OP_INSERT;
         CMD_SORT:   item_in.op = OP_SORT;
         CMD_DUMP:   item_in.op = OP_DUMP;
         default:    item_in.op = OP_NOP;
      endcase
   end

   assign busy = (cnt_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   `ALTE_ASSERT_ALWAYS(a_queue_bound, cnt_ff <= Q_CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `ALTE_ASSERT_IMPLY(a_pop_has_item, pop, head.valid, "pop from empty queue")
   `ALTE_ASSERT_NEXT(a_push_grows, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1, "push lost")

endmodule

`default_nettype wire

[src/alte_back.sv]
// Back end of the ordered list engine: list memory, count and command sequencer.
// Depends on alte_pkg and array_list_table_engine_macros.svh.
`default_nettype none
`include "array_list_table_engine_macros.svh"

module alte_back import alte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  queue_head_type       head,
   output logic                 pop,
   output logic                 rsp_valid,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [POS_W-1:0]     rsp_entry_position,
   output logic [VAL_W-1:0]     rsp_entry_value,
   output logic [RCNT_W-1:0]    rsp_list_count,
   output logic                 rsp_last
);

   logic [VAL_W-1:0]  entries_mem [DEPTH];
   logic [VAL_W-1:0]  rd_data_ff;
   logic              rd_en, wr_en;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [VAL_W-1:0]  wr_data;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  pidx_ff, pidx_in;
   logic              hold_ff, hold_in;
   logic [CNT_W-1:0]  hidx_ff, hidx_in;
   logic [CNT_W-1:0]  mcnt_ff, mcnt_in;
   logic [VAL_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]  outer_ff, outer_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [VAL_W-1:0]  rsp_val_ff, rsp_val_in;
   logic [RCNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              do_emit, e_last;
   status_type        e_status;
   logic [CNT_W-1:0]  e_pos;
   logic [VAL_W-1:0]  e_val;

   logic [CMP_W-1:0]  req_pos_wide, count_wide;
   logic [CNT_W-1:0]  idx_dn, pidx_dn, pidx_up, outer_nx;

   assign req_pos_wide = {{CNT_W{1'b0}}, head.item.position};
   assign count_wide   = {{POS_W{1'b0}}, count_ff};
   assign idx_dn       = idx_ff - CNT_W'(1);
   assign pidx_dn      = pidx_ff - CNT_W'(1);
   assign pidx_up      = pidx_ff + CNT_W'(1);
   assign outer_nx     = outer_ff + CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      val_in   = val_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      end_in   = end_ff;
      pend_in  = 1'b0;
      pidx_in  = pidx_ff;
      hold_in  = hold_ff;
      hidx_in  = hidx_ff;
      mcnt_in  = mcnt_ff;
      cur_in   = cur_ff;
      outer_in = outer_ff;
      pop      = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = idx_ff[IDX_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = count_ff[IDX_W-1:0];
      wr_data  = head.item.value;
      do_emit  = 1'b0;
      e_status = STAT_DONE;
      e_pos    = '0;
      e_val    = '0;
      e_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               op_in  = head.item.op;
               val_in = head.item.value;
               case (head.item.op)
                  OP_APPEND: begin
                     do_emit = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        e_status = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_SEARCH, OP_DUMP: begin
                     if (count_ff == '0) begin
                        do_emit  = 1'b1;
                        e_status = STAT_EMPTY;
                     end else begin
                        state_in = S_SCAN;
                        idx_in   = '0;
                        hold_in  = 1'b0;
                        mcnt_in  = '0;
                        end_in   = (head.item.op == OP_DUMP && int'(count_ff) > OUT_LIMIT)
                                   ? LIMIT_CNT : count_ff;
                     end
                  end
                  OP_DELETE: begin
                     if (req_pos_wide >= count_wide) begin
                        do_emit  = 1'b1;
                        e_status = STAT_BAD_POS;
                     end else begin
                        state_in = S_SHIFT;
                        pos_in   = req_pos_wide[CNT_W-1:0];
                        idx_in   = req_pos_wide[CNT_W-1:0] + CNT_W'(1);
                        end_in   = count_ff;
                     end
                  end
                  OP_INSERT: begin
                     if (count_ff == FULL_CNT) begin
                        do_emit  = 1'b1;
                        e_status = STAT_FULL;
                     end else if (req_pos_wide > count_wide) begin
                        do_emit  = 1'b1;
                        e_status = STAT_BAD_POS;
                     end else begin
                        state_in = S_SHIFT;
                        pos_in   = req_pos_wide[CNT_W-1:0];
                        idx_in   = count_ff;
                     end
                  end
                  OP_SORT: begin
                     if (count_ff <= CNT_W'(1)) begin
                        do_emit = 1'b1;
                     end else begin
                        state_in = S_SORT;
                        outer_in = '0;
                        idx_in   = '0;
                        end_in   = count_ff;
                     end
                  end
                  default: begin
                     do_emit = 1'b1;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (idx_ff != end_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (op_ff == OP_DUMP) begin
                  do_emit  = 1'b1;
                  e_status = STAT_ENTRY;
                  e_pos    = pidx_ff;
                  e_val    = rd_data_ff;
                  e_last   = (pidx_up == end_ff);
                  if (pidx_up == end_ff) begin
                     state_in = S_IDLE;
                  end
               end else if (rd_data_ff == val_ff) begin
                  mcnt_in = mcnt_ff + CNT_W'(1);
                  hold_in = 1'b1;
                  hidx_in = pidx_ff;
                  if (hold_ff) begin
                     do_emit  = 1'b1;
                     e_status = STAT_ENTRY;
                     e_pos    = hidx_ff;
                     e_val    = val_ff;
                     e_last   = 1'b0;
                  end
                  if (int'(mcnt_ff) + 1 == OUT_LIMIT) begin
                     state_in = S_FLUSH;
                  end
               end
            end else if (idx_ff == end_ff) begin
               state_in = S_FLUSH;
            end
         end

         S_FLUSH: begin
            do_emit  = 1'b1;
            state_in = S_IDLE;
            hold_in  = 1'b0;
            if (hold_ff) begin
               e_status = STAT_ENTRY;
               e_pos    = hidx_ff;
               e_val    = val_ff;
            end else begin
               e_status = STAT_NOT_FOUND;
            end
         end

         S_SHIFT: begin
            if (op_ff == OP_DELETE) begin
               if (idx_ff != end_ff) begin
                  rd_en   = 1'b1;
                  pend_in = 1'b1;
                  pidx_in = idx_ff;
                  idx_in  = idx_ff + CNT_W'(1);
               end
               if (pend_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = pidx_dn[IDX_W-1:0];
                  wr_data = rd_data_ff;
               end else if (idx_ff == end_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  do_emit  = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               if (idx_ff != pos_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_dn[IDX_W-1:0];
                  pend_in = 1'b1;
                  pidx_in = idx_dn;
                  idx_in  = idx_dn;
               end
               if (pend_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = pidx_up[IDX_W-1:0];
                  wr_data = rd_data_ff;
               end else if (idx_ff == pos_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = pos_ff[IDX_W-1:0];
                  wr_data  = val_ff;
                  count_in = count_ff + CNT_W'(1);
                  do_emit  = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end

         S_SORT: begin
            if (idx_ff != end_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (pidx_ff == outer_ff) begin
                  cur_in = rd_data_ff;
               end else if (cur_ff > rd_data_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = pidx_ff[IDX_W-1:0];
                  wr_data = cur_ff;
                  cur_in  = rd_data_ff;
               end
            end else if (idx_ff == end_ff) begin
               wr_en    = 1'b1;
               wr_addr  = outer_ff[IDX_W-1:0];
               wr_data  = cur_ff;
               outer_in = outer_nx;
               idx_in   = outer_nx;
               if (outer_nx + CNT_W'(1) >= count_ff) begin
                  do_emit  = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = do_emit;
      rsp_status_in = e_status;
      rsp_pos_in   = rpt_pos(e_pos);
      rsp_val_in   = e_val;
      rsp_count_in = rpt_count(count_in);
      rsp_last_in  = e_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      pidx_ff       <= pidx_in;
      hidx_ff       <= hidx_in;
      mcnt_ff       <= mcnt_in;
      cur_ff        <= cur_in;
      outer_ff      <= outer_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // List storage: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_mem[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_entry_value    = rsp_val_ff;
   assign rsp_list_count     = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

   `ALTE_ASSERT_ALWAYS(a_count_bound, count_ff <= FULL_CNT, "entry count exceeds depth")
   `ALTE_ASSERT_IMPLY(a_idle_no_read, state_ff == S_IDLE, !pend_ff, "read in flight while idle")
   `ALTE_ASSERT_IMPLY(a_scan_no_write, state_ff == S_SCAN || state_ff == S_FLUSH, !wr_en, "write during scan")

endmodule

`default_nettype wire
